### design/indexed_shift_list_unit_defines.svh
// assertion macros for the indexed shift list unit
// used by the checker only, no other dependencies
`ifndef INDEXED_SHIFT_LIST_UNIT_DEFINES_SVH
`define INDEXED_SHIFT_LIST_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ISL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define ISL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### design/isl_pkg.sv
// shared types and constants of the indexed shift list unit
// no dependencies
package isl_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CNT_OUT_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_HOLD = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   position;
    logic [FIELD_W-1:0] entry_in;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   entry_out;
    status_e              status;
    logic [CNT_OUT_W-1:0] count_after;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic cfg_we;
  } cmd_t;

endpackage

### design/indexed_shift_list_unit.sv
// Indexed shift list: an ordered list of up to DEPTH entries with push, pop,
// insert at an index and remove at an index. Each entry lives in its own
// register cell, so an insert or remove shift writes all cells together; one
// word is accepted per clock while the output is not stalled; its result word
// appears on the output register in the cycle after acceptance; a new word can
// be taken in the same cycle the previous result is drained. The output stall
// backs up to the input stall combinationally. The capacity register may be
// written at any time the list is idle and takes effect on the next word. No
// clearing pass after reset. Depends on isl_pkg, isl_ctrl and isl_datapath.
module indexed_shift_list_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  isl_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output isl_pkg::out_word_t        out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [isl_pkg::CAP_W-1:0] cfg_data_i
);
  import isl_pkg::*;

  cmd_t cmd;

  isl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  isl_datapath #(
    .DEPTH      (DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .cfg_data_i (cfg_data_i),
    .out_word_o (out_word_o)
  );

endmodule

### design/isl_ctrl.sv
// handshake controller of the indexed shift list unit
// depends on isl_pkg
module isl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  output isl_pkg::cmd_t cmd_o
);
  import isl_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    accept      = 1'b0;
    case (state_q)
      CTRL_IDLE: begin
        accept = in_valid_i;
        if (accept) begin
          state_d = CTRL_HOLD;
        end
      end
      CTRL_HOLD: begin
        out_valid_o = 1'b1;
        // result slot frees up in the same cycle it is taken
        in_stall_o  = out_stall_i;
        accept      = in_valid_i && !out_stall_i;
        if (!out_stall_i && !accept) begin
          state_d = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  assign cfg_ready_o  = 1'b1;
  assign cmd_o.exec   = accept;
  assign cmd_o.cfg_we = cfg_valid_i;

endmodule

### design/isl_datapath.sv
// entry cells, length count, capacity register and result register
// depends on isl_pkg
module isl_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  isl_pkg::cmd_t                cmd_i,
  input  isl_pkg::in_word_t            in_word_i,
  input  logic [isl_pkg::CAP_W-1:0]    cfg_data_i,
  output isl_pkg::out_word_t           out_word_o
);
  import isl_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned WW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]         count_q, count_d;
  logic [CAP_W-1:0]      cap_q;
  logic [ENTRY_BITS-1:0] cell_q     [DEPTH];
  logic [ENTRY_BITS-1:0] cell_d     [DEPTH];
  logic                  cell_we    [DEPTH];
  logic [ENTRY_BITS-1:0] below_v    [DEPTH];
  logic [ENTRY_BITS-1:0] above_v    [DEPTH];

  logic [WW-1:0]         count_w, pos_w, cap_w, cm1_w, cnt_next_w;
  logic                  full, grow, shrink, ok;
  status_e               status;
  logic [IW-1:0]         rd_idx;
  logic [ENTRY_BITS-1:0] val, taken;
  logic [FIELD_W-1:0]    taken_field;

  // entry width adaption in both directions
  if (ENTRY_BITS <= FIELD_W) begin : g_narrow
    assign val = in_word_i.entry_in[ENTRY_BITS-1:0];
    if (ENTRY_BITS < FIELD_W) begin : g_pad
      assign taken_field = {{(FIELD_W - ENTRY_BITS){1'b0}}, taken};
    end else begin : g_same
      assign taken_field = taken;
    end
  end else begin : g_wide
    assign val         = {{(ENTRY_BITS - FIELD_W){1'b0}}, in_word_i.entry_in};
    assign taken_field = taken[FIELD_W-1:0];
  end

  // neighbour taps of every cell
  for (genvar g = 0; g < DEPTH; g++) begin : g_taps
    if (g == 0) begin : g_first
      assign below_v[g] = '0;
    end else begin : g_below
      assign below_v[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign above_v[g] = '0;
    end else begin : g_above
      assign above_v[g] = cell_q[g+1];
    end
  end

  always_comb begin
    count_w = WW'(count_q);
    pos_w   = WW'(in_word_i.position);
    cap_w   = WW'(cap_q);
    cm1_w   = count_w - WW'(1);
    full    = (count_w >= cap_w) || (count_w >= WW'(DEPTH));
    status  = ST_OK;
    case (in_word_i.mode)
      MODE_PUSH: begin
        if (full) status = ST_FULL;
      end
      MODE_POP: begin
        if (count_q == '0) status = ST_EMPTY;
      end
      MODE_INSERT: begin
        if (pos_w >= count_w) status = ST_RANGE;
        else if (full)        status = ST_FULL;
      end
      default: begin
        if (pos_w >= count_w) status = ST_RANGE;
      end
    endcase
    ok     = (status == ST_OK);
    grow   = ok && ((in_word_i.mode == MODE_PUSH) || (in_word_i.mode == MODE_INSERT));
    shrink = ok && ((in_word_i.mode == MODE_POP) || (in_word_i.mode == MODE_REMOVE));

    if (grow)        cnt_next_w = count_w + WW'(1);
    else if (shrink) cnt_next_w = cm1_w;
    else             cnt_next_w = count_w;
    count_d = cnt_next_w[CW-1:0];

    rd_idx = (in_word_i.mode == MODE_POP) ? cm1_w[IW-1:0] : pos_w[IW-1:0];
    taken  = shrink ? cell_q[rd_idx] : '0;
  end

  // per-cell update, all cells of a shift are written in the same cycle
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i]  = cell_q[i];
      cell_we[i] = 1'b0;
      if (cmd_i.exec && ok) begin
        case (in_word_i.mode)
          MODE_PUSH: begin
            if (WW'(i) == count_w) begin
              cell_d[i]  = val;
              cell_we[i] = 1'b1;
            end
          end
          MODE_INSERT: begin
            if (WW'(i) == pos_w) begin
              cell_d[i]  = val;
              cell_we[i] = 1'b1;
            end else if (WW'(i) > pos_w && WW'(i) <= count_w) begin
              cell_d[i]  = below_v[i];
              cell_we[i] = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (WW'(i) >= pos_w && (WW'(i) + WW'(1)) < count_w) begin
              cell_d[i]  = above_v[i];
              cell_we[i] = 1'b1;
            end
          end
          default: begin
            cell_we[i] = 1'b0;
          end
        endcase
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cells
    always_ff @(posedge clk_i) begin
      if (cell_we[g]) begin
        cell_q[g] <= cell_d[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (cmd_i.exec) begin
        count_q <= count_d;
      end
      if (cmd_i.cfg_we) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_word_o.entry_out   <= taken_field;
      out_word_o.status      <= status;
      out_word_o.count_after <= cnt_next_w[CNT_OUT_W-1:0];
    end
  end

endmodule

### design/isl_checker.sv
// port-level checks of the indexed shift list unit, bound to the top level
// depends on isl_pkg and indexed_shift_list_unit_defines.svh
`include "indexed_shift_list_unit_defines.svh"

module isl_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input isl_pkg::out_word_t out_word_o
);
  import isl_pkg::*;

  logic in_acc, out_hold, rejected, empty_seen;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_hold   = out_valid_o && out_stall_i;
  assign rejected   = out_valid_o && (out_word_o.status != ST_OK);
  assign empty_seen = out_valid_o && (out_word_o.status == ST_EMPTY);

  // every accepted word yields a result on the next cycle
  `ISL_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_acc, out_valid_o)

  `ISL_ASSERT_NEXT(a_stalled_result_holds, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_word_o))

  // rejected operations hand back nothing
  `ISL_ASSERT_IMPL(a_reject_zero, clk_i, rst_ni, rejected, out_word_o.entry_out == '0)

  `ISL_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, empty_seen, out_word_o.count_after == '0)

endmodule

bind indexed_shift_list_unit isl_port_checks u_isl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
